>>> src/bdll_pkg.sv
// Shared types and codes for the bounded doubly linked list core.
// Used by the controller, the datapath and the top level; no dependencies.
package bdll_pkg;

   localparam int FIELD_WIDTH = 32;
   localparam int MODE_WIDTH = 3;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH = 7;
   localparam int REQ_DATA_WIDTH = 72;
   localparam int RSP_DATA_WIDTH = 80;

   localparam logic [MODE_WIDTH-1:0] MODE_APPEND = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_PREPEND = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_INSERT_AFTER = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_POP_FRONT = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_POP_BACK = 3'd4;
   localparam logic [MODE_WIDTH-1:0] MODE_DELETE = 3'd5;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL = 2'd3;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_START_ALLOC,
      CMD_START_WALK,
      CMD_STEP,
      CMD_START_UNL_HEAD,
      CMD_START_UNL_TAIL,
      CMD_START_UNL_CUR,
      CMD_UNLINK,
      CMD_UNL_VAL,
      CMD_ALLOC,
      CMD_LINK,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [STATUS_WIDTH-1:0] status;
   } ctrl_type;

   typedef struct packed {
      logic                  empty;
      logic                  full;
      logic                  match;
      logic                  walk_end;
      logic [MODE_WIDTH-1:0] mode;
   } stat_type;

endpackage

>>> src/bounded_doubly_linked_list_core.sv
// Bounded doubly linked list core: one request beat in, one response beat out.
// Insert-after and delete walk the list from the head, one node per cycle, and compare
// at most CAPACITY nodes. One operation at a time: a new request is taken only once
// the previous one has finished. Synchronous reset empties the list.
module bounded_doubly_linked_list_core #(
   parameter int CAPACITY = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // mode[2:0], key[34:3], value[66:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata   // status[1:0], count[8:2], head_value[40:9],
                                   // tail_value[72:41], nonempty[73]
);
   import bdll_pkg::*;

   ctrl_type ctrl;
   stat_type stat;
   logic [STATUS_WIDTH-1:0] status;
   logic [COUNT_WIDTH-1:0] count;
   logic signed [FIELD_WIDTH-1:0] head_value, tail_value;
   logic nonempty;

   bdll_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .stat(stat), .ctrl(ctrl)
   );

   bdll_dpath #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dpath (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .req_mode(req_tdata[2:0]),
      .req_key($signed(req_tdata[34:3])),
      .req_value($signed(req_tdata[66:35])),
      .rsp_status(status), .rsp_count(count),
      .rsp_head_value(head_value), .rsp_tail_value(tail_value),
      .rsp_nonempty(nonempty)
   );

   assign rsp_tdata = {6'd0, nonempty, tail_value, head_value, count, status};

endmodule

>>> src/bdll_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> src/bdll_ctrl.sv
// Sequencer for the list core: walks each operation through its steps.
// Depends on bdll_pkg; drives commands into bdll_dpath.
module bdll_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  bdll_pkg::stat_type stat,
   output bdll_pkg::ctrl_type ctrl
);
   import bdll_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DISPATCH, ST_WALK, ST_UNL_RD, ST_UNL_VAL, ST_ALLOC, ST_LINK, ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   cmd_type                 cmd;

   always_comb begin
      state_in = state_ff;
      status_in = status_ff;
      cmd = CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd = CMD_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            status_in = STATUS_OK;
            state_in = ST_DONE;
            case (stat.mode)
               MODE_APPEND, MODE_PREPEND: begin
                  if (stat.full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     cmd = CMD_START_ALLOC;
                     state_in = ST_ALLOC;
                  end
               end
               MODE_INSERT_AFTER, MODE_DELETE: begin
                  if (stat.empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     cmd = CMD_START_WALK;
                     state_in = ST_WALK;
                  end
               end
               MODE_POP_FRONT: begin
                  if (stat.empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     cmd = CMD_START_UNL_HEAD;
                     state_in = ST_UNL_RD;
                  end
               end
               MODE_POP_BACK: begin
                  if (stat.empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     cmd = CMD_START_UNL_TAIL;
                     state_in = ST_UNL_RD;
                  end
               end
               default: ;
            endcase
         end
         ST_WALK: begin
            if (stat.match) begin
               if (stat.mode == MODE_DELETE) begin
                  cmd = CMD_START_UNL_CUR;
                  state_in = ST_UNL_RD;
               end else if (stat.full) begin
                  status_in = STATUS_FULL;
                  state_in = ST_DONE;
               end else begin
                  cmd = CMD_START_ALLOC;
                  state_in = ST_ALLOC;
               end
            end else if (stat.walk_end) begin
               status_in = STATUS_NOT_FOUND;
               state_in = ST_DONE;
            end else begin
               cmd = CMD_STEP;
            end
         end
         ST_UNL_RD: begin
            cmd = CMD_UNLINK;
            state_in = ST_UNL_VAL;
         end
         ST_UNL_VAL: begin
            cmd = CMD_UNL_VAL;
            state_in = ST_DONE;
         end
         ST_ALLOC: begin
            cmd = CMD_ALLOC;
            state_in = ST_LINK;
         end
         ST_LINK: begin
            cmd = CMD_LINK;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the previous result beat has left
            if (!rsp_valid_ff || rsp_tready) begin
               cmd = CMD_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_tready) || (cmd == CMD_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         status_ff <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign ctrl.cmd = cmd;
   assign ctrl.status = status_ff;

endmodule

>>> src/bdll_dpath.sv
// Datapath of the list core: node pool RAMs, free-slot stack, head/tail
// registers and the result register. Depends on bdll_pkg and bdll_ram.
module bdll_dpath #(
   parameter int CAPACITY = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bdll_pkg::ctrl_type                  ctrl,
   output bdll_pkg::stat_type                  stat,
   input  logic [bdll_pkg::MODE_WIDTH-1:0]     req_mode,
   input  logic signed [bdll_pkg::FIELD_WIDTH-1:0] req_key,
   input  logic signed [bdll_pkg::FIELD_WIDTH-1:0] req_value,
   output logic [bdll_pkg::STATUS_WIDTH-1:0]   rsp_status,
   output logic [bdll_pkg::COUNT_WIDTH-1:0]    rsp_count,
   output logic signed [bdll_pkg::FIELD_WIDTH-1:0] rsp_head_value,
   output logic signed [bdll_pkg::FIELD_WIDTH-1:0] rsp_tail_value,
   output logic                                rsp_nonempty
);
   import bdll_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);
   localparam logic [LW-1:0] LAST_STEP = LW'(CAPACITY - 1);

   logic [MODE_WIDTH-1:0] mode_ff, mode_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in, val_ff, val_in;
   logic [LW-1:0] head_ff, head_in, tail_ff, tail_in, cnt_ff, cnt_in;
   logic [LW-1:0] top_ff, top_in, lwm_ff, lwm_in, fidx_ff, fidx_in;
   logic [LW-1:0] cur_ff, cur_in, nxt_ff, nxt_in, victim_ff, victim_in;
   logic [LW-1:0] slot_ff, slot_in, steps_ff, steps_in;
   logic [DATA_WIDTH-1:0] head_val_ff, head_val_in, tail_val_ff, tail_val_in;
   logic pnull_ff, pnull_in, nnull_ff, nnull_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [FIELD_WIDTH-1:0] hv_ff, hv_in, tv_ff, tv_in;
   logic nonempty_ff, nonempty_in;

   logic v_we, n_we, p_we, f_we;
   logic [AW-1:0] v_wa, n_wa, p_wa, f_wa, v_ra, n_ra, p_ra, f_ra;
   logic [DATA_WIDTH-1:0] v_wd, v_rd;
   logic [LW-1:0] n_wd, p_wd, n_rd, p_rd;
   logic [AW-1:0] f_wd, f_rd;

   logic [DATA_WIDTH-1:0] target;
   logic [LW-1:0] free_slot, alloc_slot;
   logic empty;

   assign empty = !(head_ff < NULL_LINK);
   assign target = (mode_ff == MODE_DELETE) ? val_ff : key_ff;
   // slots below the low-water mark still hold their reset order
   assign free_slot = (fidx_ff < lwm_ff) ? (LAST_STEP - fidx_ff) : LW'(f_rd);

   assign stat.empty = empty;
   assign stat.full = (top_ff == '0);
   assign stat.match = (v_rd == target);
   assign stat.walk_end = !(n_rd < NULL_LINK) || (steps_ff == LAST_STEP);
   assign stat.mode = mode_ff;

   always_comb begin
      mode_in = mode_ff; key_in = key_ff; val_in = val_ff;
      head_in = head_ff; tail_in = tail_ff; cnt_in = cnt_ff;
      top_in = top_ff; lwm_in = lwm_ff; fidx_in = fidx_ff;
      cur_in = cur_ff; nxt_in = nxt_ff; victim_in = victim_ff;
      slot_in = slot_ff; steps_in = steps_ff;
      head_val_in = head_val_ff; tail_val_in = tail_val_ff;
      pnull_in = pnull_ff; nnull_in = nnull_ff;
      status_in = status_ff; count_in = count_ff;
      hv_in = hv_ff; tv_in = tv_ff; nonempty_in = nonempty_ff;
      alloc_slot = free_slot;
      v_we = 1'b0; n_we = 1'b0; p_we = 1'b0; f_we = 1'b0;
      v_wa = '0; n_wa = '0; p_wa = '0; f_wa = '0;
      v_wd = val_ff; n_wd = NULL_LINK; p_wd = NULL_LINK; f_wd = '0;
      v_ra = '0; n_ra = '0; p_ra = '0; f_ra = '0;
      case (ctrl.cmd)
         CMD_LOAD: begin
            mode_in = req_mode;
            key_in = DATA_WIDTH'(req_key);
            val_in = DATA_WIDTH'(req_value);
         end
         CMD_START_ALLOC: begin
            nxt_in = n_rd;
            top_in = top_ff - 1'b1;
            fidx_in = top_ff - 1'b1;
            f_ra = top_in[AW-1:0];
         end
         CMD_START_WALK: begin
            cur_in = head_ff;
            steps_in = '0;
            v_ra = head_ff[AW-1:0];
            n_ra = head_ff[AW-1:0];
         end
         CMD_STEP: begin
            cur_in = n_rd;
            steps_in = steps_ff + 1'b1;
            v_ra = n_rd[AW-1:0];
            n_ra = n_rd[AW-1:0];
         end
         CMD_START_UNL_HEAD, CMD_START_UNL_TAIL, CMD_START_UNL_CUR: begin
            if (ctrl.cmd == CMD_START_UNL_HEAD) begin
               victim_in = head_ff;
            end else if (ctrl.cmd == CMD_START_UNL_TAIL) begin
               victim_in = tail_ff;
            end else begin
               victim_in = cur_ff;
            end
            n_ra = victim_in[AW-1:0];
            p_ra = victim_in[AW-1:0];
         end
         CMD_UNLINK: begin
            pnull_in = !(p_rd < NULL_LINK);
            nnull_in = !(n_rd < NULL_LINK);
            if (pnull_in) begin
               head_in = nnull_in ? NULL_LINK : n_rd;
            end else begin
               n_we = 1'b1; n_wa = p_rd[AW-1:0]; n_wd = n_rd;
            end
            if (nnull_in) begin
               tail_in = pnull_in ? NULL_LINK : p_rd;
            end else begin
               p_we = 1'b1; p_wa = n_rd[AW-1:0]; p_wd = p_rd;
            end
            // push the freed slot
            f_we = 1'b1; f_wa = top_ff[AW-1:0]; f_wd = victim_ff[AW-1:0];
            top_in = top_ff + 1'b1;
            if (top_ff < lwm_ff) begin
               lwm_in = top_ff;
            end
            cnt_in = cnt_ff - 1'b1;
            v_ra = pnull_in ? n_rd[AW-1:0] : p_rd[AW-1:0];
         end
         CMD_UNL_VAL: begin
            if (pnull_ff) begin
               head_val_in = v_rd;
            end
            if (nnull_ff) begin
               tail_val_in = v_rd;
            end
         end
         CMD_ALLOC: begin
            slot_in = alloc_slot;
            v_we = 1'b1; v_wa = alloc_slot[AW-1:0]; v_wd = val_ff;
            n_we = 1'b1; n_wa = alloc_slot[AW-1:0];
            p_we = 1'b1; p_wa = alloc_slot[AW-1:0];
            case (mode_ff)
               MODE_APPEND: begin
                  n_wd = NULL_LINK;
                  p_wd = empty ? NULL_LINK : tail_ff;
               end
               MODE_PREPEND: begin
                  n_wd = empty ? NULL_LINK : head_ff;
                  p_wd = NULL_LINK;
               end
               default: begin
                  n_wd = nxt_ff;
                  p_wd = cur_ff;
               end
            endcase
         end
         CMD_LINK: begin
            cnt_in = cnt_ff + 1'b1;
            case (mode_ff)
               MODE_APPEND: begin
                  if (empty) begin
                     head_in = slot_ff; head_val_in = val_ff;
                  end else begin
                     n_we = 1'b1; n_wa = tail_ff[AW-1:0]; n_wd = slot_ff;
                  end
                  tail_in = slot_ff; tail_val_in = val_ff;
               end
               MODE_PREPEND: begin
                  if (empty) begin
                     tail_in = slot_ff; tail_val_in = val_ff;
                  end else begin
                     p_we = 1'b1; p_wa = head_ff[AW-1:0]; p_wd = slot_ff;
                  end
                  head_in = slot_ff; head_val_in = val_ff;
               end
               default: begin
                  n_we = 1'b1; n_wa = cur_ff[AW-1:0]; n_wd = slot_ff;
                  if (nxt_ff < NULL_LINK) begin
                     p_we = 1'b1; p_wa = nxt_ff[AW-1:0]; p_wd = slot_ff;
                  end else begin
                     tail_in = slot_ff; tail_val_in = val_ff;
                  end
               end
            endcase
         end
         CMD_FINISH: begin
            status_in = ctrl.status;
            count_in = COUNT_WIDTH'(cnt_ff);
            nonempty_in = (head_ff < NULL_LINK) && (tail_ff < NULL_LINK);
            hv_in = nonempty_in ? FIELD_WIDTH'(head_val_ff) : '0;
            tv_in = nonempty_in ? FIELD_WIDTH'(tail_val_ff) : '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= NULL_LINK;
         tail_ff <= NULL_LINK;
         cnt_ff <= '0;
         top_ff <= NULL_LINK;
         lwm_ff <= NULL_LINK;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff <= cnt_in;
         top_ff <= top_in;
         lwm_ff <= lwm_in;
      end
      mode_ff <= mode_in; key_ff <= key_in; val_ff <= val_in;
      fidx_ff <= fidx_in; cur_ff <= cur_in; nxt_ff <= nxt_in;
      victim_ff <= victim_in; slot_ff <= slot_in; steps_ff <= steps_in;
      head_val_ff <= head_val_in; tail_val_ff <= tail_val_in;
      pnull_ff <= pnull_in; nnull_ff <= nnull_in;
      status_ff <= status_in; count_ff <= count_in;
      hv_ff <= hv_in; tv_ff <= tv_in; nonempty_ff <= nonempty_in;
   end

   bdll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
      .clock(clock), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_addr(v_ra), .rd_data(v_rd)
   );

   bdll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next_ram (
      .clock(clock), .wr_en(n_we), .wr_addr(n_wa), .wr_data(n_wd),
      .rd_addr(n_ra), .rd_data(n_rd)
   );

   bdll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev_ram (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd)
   );

   bdll_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free_ram (
      .clock(clock), .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_addr(f_ra), .rd_data(f_rd)
   );

   assign rsp_status = status_ff;
   assign rsp_count = count_ff;
   assign rsp_head_value = hv_ff;
   assign rsp_tail_value = tv_ff;
   assign rsp_nonempty = nonempty_ff;

endmodule

>>> src/bdll_checker.sv
// Port-level checks for the list core, bound to the top level.
// Depends on bounded_doubly_linked_list_core's ports only.
module bdll_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[73] |->
         rsp_tdata[8:2] == 7'd0 && rsp_tdata[72:9] == 64'd0)
      else $error("empty list shows elements");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == 2'd1 |-> !rsp_tdata[73])
      else $error("empty status with nonempty list");

endmodule

bind bounded_doubly_linked_list_core bdll_checker u_bdll_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
